// File: rtl/core/command_frame_encoder_defines.svh
// Assertion macros used by the checker file of the command frame encoder.
`ifndef COMMAND_FRAME_ENCODER_DEFINES_SVH
`define COMMAND_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CFE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfe assertion failed");

// Next-cycle implication, disabled during reset.
`define CFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfe assertion failed");

`endif

// File: rtl/core/cfe_pkg.sv
// Types, constants and mnemonic tables of the command frame encoder.
`default_nettype none
package cfe_pkg;

   localparam logic [7:0]  BYTE_STX    = 8'h02;
   localparam logic [7:0]  BYTE_SPACE  = 8'h20;
   localparam logic [7:0]  BYTE_SEMI   = 8'h3B;
   localparam logic [7:0]  BYTE_CR     = 8'h0D;
   localparam logic [7:0]  BYTE_LF     = 8'h0A;
   localparam logic [7:0]  BYTE_DIGIT0 = 8'h30;
   localparam logic [7:0]  CHK_OR      = 8'h40;
   localparam logic [15:0] MAX_VALUE   = 16'd4095;
   localparam logic [4:0]  NUM_COMMANDS = 5'd22;
   // floor(v*3277 / 2^15) == floor(v/10) for v <= 4095
   localparam logic [11:0] RECIP_TEN   = 12'd3277;
   localparam int          RECIP_SHIFT = 15;
   localparam logic [2:0]  MAX_DIGITS  = 3'd4;

   typedef enum logic [4:0] {
      CMD_VREF, CMD_IREF, CMD_VSET, CMD_ISET, CMD_VMON, CMD_IMON, CMD_FMON,
      CMD_ENBL, CMD_WDTE, CMD_WDTT, CMD_CLR,  CMD_FLT,  CMD_STAT, CMD_FREV,
      CMD_SLVR, CMD_SLIR, CMD_MODR, CMD_HWVR, CMD_SOFT, CMD_LVPS, CMD_TEMP,
      CMD_BAUD
   } command_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CONV, ST_STX, ST_MNEM, ST_DIGIT, ST_SEMI, ST_CHK, ST_CR,
      ST_LF, ST_BAD
   } state_type;

   typedef struct packed {
      logic [11:0] quotient;
      logic [3:0]  remainder;
   } digit_result_type;

   // Mnemonic characters, first character in the top byte; unused slots are zero.
   function automatic logic [39:0] mnemonic_text(input logic [4:0] cmd);
      logic [39:0] t;
      case (cmd)
         CMD_VREF: t = {"VREF", BYTE_SPACE};
         CMD_IREF: t = {"IREF", BYTE_SPACE};
         CMD_VSET: t = {"VSET", 8'h00};
         CMD_ISET: t = {"ISET", 8'h00};
         CMD_VMON: t = {"VMON", 8'h00};
         CMD_IMON: t = {"IMON", 8'h00};
         CMD_FMON: t = {"FMON", 8'h00};
         CMD_ENBL: t = {"ENBL", BYTE_SPACE};
         CMD_WDTE: t = {"WDTE", BYTE_SPACE};
         CMD_WDTT: t = {"WDTT", 8'h00};
         CMD_CLR:  t = {"CLR", 16'h0000};
         CMD_FLT:  t = {"FLT", 16'h0000};
         CMD_STAT: t = {"STAT", 8'h00};
         CMD_FREV: t = {"FREV", 8'h00};
         CMD_SLVR: t = {"SLVR", 8'h00};
         CMD_SLIR: t = {"SLIR", 8'h00};
         CMD_MODR: t = {"MODR", 8'h00};
         CMD_HWVR: t = {"HWVR", 8'h00};
         CMD_SOFT: t = {"SOFT", 8'h00};
         CMD_LVPS: t = {"LVPS", 8'h00};
         CMD_TEMP: t = {"TEMP", 8'h00};
         CMD_BAUD: t = {"BAUD", BYTE_SPACE};
         default:  t = 40'h0;
      endcase
      return t;
   endfunction

   function automatic logic [2:0] mnemonic_len(input logic [4:0] cmd);
      logic [2:0] n;
      case (cmd)
         CMD_VREF, CMD_IREF, CMD_ENBL, CMD_WDTE, CMD_BAUD: n = 3'd5;
         CMD_CLR, CMD_FLT:                                 n = 3'd3;
         default:                                          n = 3'd4;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] mnemonic_char(input logic [4:0] cmd,
                                                input logic [2:0] idx);
      logic [39:0] t;
      logic [7:0]  c;
      t = mnemonic_text(cmd);
      case (idx)
         3'd0:    c = t[39:32];
         3'd1:    c = t[31:24];
         3'd2:    c = t[23:16];
         3'd3:    c = t[15:8];
         3'd4:    c = t[7:0];
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/cfe_digit_unit.sv
// Shared divide-by-ten step: quotient and remainder of one decimal digit.
`default_nettype none
module cfe_digit_unit (
   input  wire logic [11:0]               operand,
   output cfe_pkg::digit_result_type      result
);
   import cfe_pkg::*;

   logic [23:0] product;
   logic [8:0]  quot;
   logic [11:0] quot_x10;

   assign product  = 24'(operand) * 24'(RECIP_TEN);
   assign quot     = product[RECIP_SHIFT +: 9];
   assign quot_x10 = 12'({quot, 3'b000}) + 12'({quot, 1'b0});

   assign result.quotient  = 12'(quot);
   assign result.remainder = 4'(operand - quot_x10);

endmodule
`default_nettype wire

// File: rtl/core/command_frame_encoder.sv
// Top level: command to serial frame byte sequencer with checksum.
//
//   channel | direction | fields                                  | handshake
//   req     | in        | command[4:0], has_value, value[15:0]    | req_valid/req_ready
//   rsp     | out       | frame_byte[7:0], last, bad_command      | rsp_valid/rsp_ready
//
// One command is accepted, then converted one argument digit at a time in the
// divide-by-ten unit, then sent one frame byte (8 to 14 bytes) at a time through
// the single output register, which stalls while rsp_ready is low.
// An unknown code gives one flagged beat.
// Reset (synchronous) returns the sequencer to idle and empties the output.
// A stalled rsp holds the byte sequencer; req_ready is high only when idle.
`default_nettype none
module command_frame_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [4:0]  req_command,
   input  wire logic        req_has_value,
   input  wire logic [15:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_frame_byte,
   output logic             rsp_last,
   output logic             rsp_bad_command
);
   import cfe_pkg::*;

   state_type        state_ff, state_in;
   logic [4:0]       command_ff, command_in;
   logic [11:0]      value_ff, value_in;
   logic [3:0]       digit_store_ff [4];
   logic [2:0]       digit_count_ff, digit_count_in;
   logic [2:0]       char_idx_ff, char_idx_in;
   logic [2:0]       digit_idx_ff, digit_idx_in;
   logic [9:0]       sum_ff, sum_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff, rsp_bad_ff;

   digit_result_type div_result;
   logic             accept, out_free, conv_done, mnem_done;
   logic [2:0]       mnem_len;
   logic [1:0]       digit_sel;
   logic             load, load_last, load_bad, load_summed;
   logic [7:0]       load_byte;
   logic [6:0]       chk_low;

   cfe_digit_unit u_digit (
      .operand (value_ff),
      .result  (div_result)
   );

   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign mnem_len  = mnemonic_len(command_ff);
   assign mnem_done = (char_idx_ff == mnem_len - 3'd1);
   assign conv_done = (div_result.quotient == 12'd0) ||
                      (digit_count_ff == MAX_DIGITS - 3'd1);
   assign digit_sel = 2'(digit_idx_ff - 3'd1);
   assign chk_low   = 7'd0 - sum_ff[6:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command >= NUM_COMMANDS) state_in = ST_BAD;
               else if (req_has_value)         state_in = ST_CONV;
               else                            state_in = ST_STX;
            end
         end
         ST_CONV:  if (conv_done) state_in = ST_STX;
         ST_STX:   if (out_free) state_in = ST_MNEM;
         ST_MNEM: begin
            if (out_free && mnem_done)
               state_in = (digit_count_ff != 3'd0) ? ST_DIGIT : ST_SEMI;
         end
         ST_DIGIT: if (out_free && digit_idx_ff == 3'd1) state_in = ST_SEMI;
         ST_SEMI:  if (out_free) state_in = ST_CHK;
         ST_CHK:   if (out_free) state_in = ST_CR;
         ST_CR:    if (out_free) state_in = ST_LF;
         ST_LF:    if (out_free) state_in = ST_IDLE;
         ST_BAD:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready   = 1'b0;
      load        = 1'b0;
      load_byte   = 8'h00;
      load_last   = 1'b0;
      load_bad    = 1'b0;
      load_summed = 1'b0;
      case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_CONV:  ;
         ST_STX: begin
            load      = out_free;
            load_byte = BYTE_STX;
         end
         ST_MNEM: begin
            load        = out_free;
            load_byte   = mnemonic_char(command_ff, char_idx_ff);
            load_summed = 1'b1;
         end
         ST_DIGIT: begin
            load        = out_free;
            load_byte   = BYTE_DIGIT0 | {4'h0, digit_store_ff[digit_sel]};
            load_summed = 1'b1;
         end
         ST_SEMI: begin
            load        = out_free;
            load_byte   = BYTE_SEMI;
            load_summed = 1'b1;
         end
         ST_CHK: begin
            load      = out_free;
            load_byte = {1'b0, chk_low} | CHK_OR;
         end
         ST_CR: begin
            load      = out_free;
            load_byte = BYTE_CR;
         end
         ST_LF: begin
            load      = out_free;
            load_byte = BYTE_LF;
            load_last = 1'b1;
         end
         ST_BAD: begin
            load      = out_free;
            load_last = 1'b1;
            load_bad  = 1'b1;
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      command_in     = command_ff;
      value_in       = value_ff;
      digit_count_in = digit_count_ff;
      char_idx_in    = char_idx_ff;
      digit_idx_in   = digit_idx_ff;
      sum_in         = sum_ff;
      if (accept) begin
         command_in     = req_command;
         value_in       = (req_value > MAX_VALUE) ? MAX_VALUE[11:0] : req_value[11:0];
         digit_count_in = 3'd0;
         char_idx_in    = 3'd0;
         sum_in         = 10'd0;
      end
      if (state_ff == ST_CONV) begin
         value_in       = div_result.quotient;
         digit_count_in = digit_count_ff + 3'd1;
      end
      if (state_ff == ST_STX) digit_idx_in = digit_count_ff;
      if (load && state_ff == ST_MNEM)  char_idx_in  = char_idx_ff + 3'd1;
      if (load && state_ff == ST_DIGIT) digit_idx_in = digit_idx_ff - 3'd1;
      if (load && load_summed) sum_in = sum_ff + 10'(load_byte);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         command_ff     <= 5'd0;
         digit_count_ff <= 3'd0;
         char_idx_ff    <= 3'd0;
         digit_idx_ff   <= 3'd0;
         sum_ff         <= 10'd0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         command_ff     <= command_in;
         digit_count_ff <= digit_count_in;
         char_idx_ff    <= char_idx_in;
         digit_idx_ff   <= digit_idx_in;
         sum_ff         <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (state_ff == ST_CONV) digit_store_ff[digit_count_ff[1:0]] <= div_result.remainder;
      if (load) begin
         rsp_byte_ff <= load_byte;
         rsp_last_ff <= load_last;
         rsp_bad_ff  <= load_bad;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_byte  = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_bad_command = rsp_bad_ff;

endmodule
`default_nettype wire

// File: rtl/core/cfe_checker.sv
// Port-level assertions for the command frame encoder, bound to the top level.
`default_nettype none
`include "command_frame_encoder_defines.svh"
module cfe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_frame_byte,
   input wire logic        rsp_last,
   input wire logic        rsp_bad_command
);
   import cfe_pkg::*;

   logic bad_beat, frame_end_beat, req_beat;

   assign req_beat       = req_valid && req_ready;
   assign bad_beat       = rsp_valid && rsp_bad_command;
   assign frame_end_beat = rsp_valid && rsp_last && !rsp_bad_command;

   // a stalled result holds its payload
   `CFE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_last) && $stable(rsp_bad_command))
   // unknown code gives a single zero beat
   `CFE_ASSERT_NOW(a_bad_form, clock, reset, bad_beat,
      rsp_last && rsp_frame_byte == 8'h00)
   // every frame closes with LF
   `CFE_ASSERT_NOW(a_frame_end, clock, reset, frame_end_beat, rsp_frame_byte == BYTE_LF)
   // one command at a time
   `CFE_ASSERT_NEXT(a_busy_after_req, clock, reset, req_beat, !req_ready)

endmodule

bind command_frame_encoder cfe_checker u_cfe_checker (.*);
`default_nettype wire

// File: test/tb_top.sv
// Testbench for command_frame_encoder: directed and randomized command beats checked byte by byte.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cfe_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_COMMANDS = 85;

   typedef struct {
      logic [4:0]  command;
      logic        has_value;
      logic [15:0] value;
      bit          hold;       // wait for all frames to drain before this beat
   } command_item_type;

   typedef struct {
      logic [7:0] frame_byte;
      logic       last;
      logic       bad_command;
   } frame_beat_type;

   typedef enum {READY_ALWAYS, READY_PATTERN, READY_RANDOM} ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [4:0]  req_command = '0;
   logic        req_has_value = 1'b0;
   logic [15:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last;
   logic        rsp_bad_command;

   command_item_type pending_cmds[$];
   frame_beat_type   beats_due[$];
   int               mismatches = 0;
   int               cycle_count = 0;
   logic             drained = 1'b1;
   int               burst_left = 1;
   int               gap_left = 0;
   ready_mode_type   ready_mode = READY_ALWAYS;
   logic [15:0]      ready_bits = '1;
   int               ready_phase = 0;

   command_frame_encoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_has_value   (req_has_value),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_frame_byte  (rsp_frame_byte),
      .rsp_last        (rsp_last),
      .rsp_bad_command (rsp_bad_command)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report(input string what);
      $display("%0t tb_top: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic queue_command(input int cmd, input int hv, input int val, input bit hold);
      command_item_type item;
      item.command   = 5'(cmd);
      item.has_value = 1'(hv);
      item.value     = 16'(val);
      item.hold      = hold;
      pending_cmds.push_back(item);
   endtask

   // Builds the byte sequence of one frame and queues it as expected beats.
   task automatic predict_frame(input logic [4:0] cmd, input logic hv, input logic [15:0] arg);
      string          mnem;
      logic [7:0]     body[$];
      int             digits[4];
      int             ndig;
      int             num;
      int             sum;
      int             chk;
      frame_beat_type beat;
      beat.last        = 1'b0;
      beat.bad_command = 1'b0;
      if (cmd >= NUM_COMMANDS) begin
         beat.frame_byte  = 8'h00;
         beat.last        = 1'b1;
         beat.bad_command = 1'b1;
         beats_due.push_back(beat);
      end else begin
         case (command_type'(cmd))
            CMD_VREF: mnem = "VREF ";
            CMD_IREF: mnem = "IREF ";
            CMD_VSET: mnem = "VSET";
            CMD_ISET: mnem = "ISET";
            CMD_VMON: mnem = "VMON";
            CMD_IMON: mnem = "IMON";
            CMD_FMON: mnem = "FMON";
            CMD_ENBL: mnem = "ENBL ";
            CMD_WDTE: mnem = "WDTE ";
            CMD_WDTT: mnem = "WDTT";
            CMD_CLR:  mnem = "CLR";
            CMD_FLT:  mnem = "FLT";
            CMD_STAT: mnem = "STAT";
            CMD_FREV: mnem = "FREV";
            CMD_SLVR: mnem = "SLVR";
            CMD_SLIR: mnem = "SLIR";
            CMD_MODR: mnem = "MODR";
            CMD_HWVR: mnem = "HWVR";
            CMD_SOFT: mnem = "SOFT";
            CMD_LVPS: mnem = "LVPS";
            CMD_TEMP: mnem = "TEMP";
            default:  mnem = "BAUD ";
         endcase
         for (int i = 0; i < mnem.len(); i++)
            body.push_back(8'(mnem[i]));
         if (hv) begin
            num = (int'(arg) > int'(MAX_VALUE)) ? int'(MAX_VALUE) : int'(arg);
            ndig = 0;
            do begin
               digits[ndig] = num % 10;
               num = num / 10;
               ndig++;
            end while (num != 0 && ndig < 4);
            for (int i = ndig - 1; i >= 0; i--)
               body.push_back(BYTE_DIGIT0 + 8'(digits[i]));
         end
         body.push_back(BYTE_SEMI);
         sum = 0;
         foreach (body[i])
            sum = (sum + int'(body[i])) & 'h3FF;
         chk = (((sum ^ 4095) + 1) & 'h7F) | int'(CHK_OR);

         beat.frame_byte = BYTE_STX;
         beats_due.push_back(beat);
         foreach (body[i]) begin
            beat.frame_byte = body[i];
            beats_due.push_back(beat);
         end
         beat.frame_byte = 8'(chk);
         beats_due.push_back(beat);
         beat.frame_byte = BYTE_CR;
         beats_due.push_back(beat);
         beat.frame_byte = BYTE_LF;
         beat.last       = 1'b1;
         beats_due.push_back(beat);
      end
   endtask

   // Request driver: bursts of beats separated by random gaps.
   always @(posedge clock) begin : driver
      command_item_type item;
      if (reset) begin
         req_valid     <= 1'b0;
         req_command   <= '0;
         req_has_value <= 1'b0;
         req_value     <= '0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 18);
            end
         end
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() != 0 &&
                      (!pending_cmds[0].hold || (!req_valid && drained))) begin
            item = pending_cmds.pop_front();
            req_command   <= item.command;
            req_has_value <= item.has_value;
            req_value     <= item.value;
            req_valid     <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side backpressure, mode reshuffled each time its phase counter runs out.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (ready_phase == 0) begin
            ready_mode  = ready_mode_type'($urandom_range(0, 2));
            ready_bits  = 16'($urandom);
            ready_phase = $urandom_range(20, 60);
         end else begin
            ready_phase--;
         end
         case (ready_mode)
            READY_ALWAYS:  rsp_ready <= 1'b1;
            READY_PATTERN: rsp_ready <= ready_bits[ready_phase % 16];
            default:       rsp_ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Monitor: checks response beats, then predicts from the accepted request.
   always @(posedge clock) begin : monitor
      frame_beat_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (beats_due.size() == 0) begin
               report($sformatf("unexpected beat byte=%02h last=%b bad=%b",
                                rsp_frame_byte, rsp_last, rsp_bad_command));
            end else begin
               want = beats_due.pop_front();
               if (rsp_frame_byte !== want.frame_byte)
                  report($sformatf("frame_byte %02h, want %02h",
                                   rsp_frame_byte, want.frame_byte));
               if (rsp_last !== want.last)
                  report($sformatf("last %b, want %b (byte %02h)",
                                   rsp_last, want.last, want.frame_byte));
               if (rsp_bad_command !== want.bad_command)
                  report($sformatf("bad_command %b, want %b (byte %02h)",
                                   rsp_bad_command, want.bad_command, want.frame_byte));
            end
         end
         if (req_valid && req_ready)
            predict_frame(req_command, req_has_value, req_value);
      end
      drained <= (beats_due.size() == 0);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      int dir_value[22];
      int cmd;
      int kind;
      int val;
      dir_value = '{0, 4095, 4096, 65535, 9, 10, 99, 1, 100, 0, 999,
                    1000, 7, 65535, 12345, 4094, 5, 42, 2048, 1023, 300, 65535};

      // directed: every command, digit count edges, saturation, unknown codes
      for (int c = 0; c < 22; c++)
         queue_command(c, (c % 6 != 3), dir_value[c], 1'b0);
      queue_command(22, 0, 0, 1'b0);
      queue_command(31, 1, 65535, 1'b0);
      queue_command(CMD_CLR, 1, 0, 1'b0);

      for (int n = 0; n < RANDOM_COMMANDS; n++) begin
         cmd = ($urandom_range(0, 9) == 0) ? $urandom_range(22, 31) : $urandom_range(0, 21);
         kind = $urandom_range(0, 4);
         case (kind)
            0:       val = $urandom_range(0, 9);
            1:       val = $urandom_range(10, 999);
            2:       val = $urandom_range(1000, 4095);
            3:       val = $urandom_range(4096, 65535);
            default: val = $urandom_range(0, 65535);
         endcase
         queue_command(cmd, ($urandom_range(0, 3) != 0), val,
                       (n == 0) || ($urandom_range(0, 29) == 0));
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_valid) @(negedge clock);
      while (beats_due.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);

      if (beats_due.size() != 0)
         report($sformatf("%0d beats never arrived", beats_due.size()));
      if (mismatches == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/cfe_pkg.sv
rtl/core/cfe_digit_unit.sv
rtl/core/command_frame_encoder.sv
rtl/core/cfe_checker.sv
test/tb_top.sv
